// ===== rtl/core/cdn_pkg.sv =====
`timescale 1ns / 1ps

package cdn_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned CFG_W    = 14;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned COUNT_W  = 23;
  localparam int unsigned DN_W     = 22;
  localparam int unsigned WD_W     = 3;
  localparam int unsigned LY_W     = 15;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned Q100_W   = 8;
  localparam int unsigned Q400_W   = 6;
  localparam int unsigned R400_W   = 18;
  localparam int unsigned R100_W   = 16;
  localparam int unsigned Q4_W     = 5;
  localparam int unsigned R4_W     = 11;

  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // Reciprocals for division by constants; each quotient is low by at most one.
  localparam int unsigned RECIP100_SH = 19;
  localparam int unsigned RECIP100    = 5243;
  localparam int unsigned PROD100_W   = YEAR_W + 13;
  localparam int unsigned RECIP400_SH = COUNT_W;
  localparam int unsigned RECIP400    = (1 << RECIP400_SH) / DAYS_400Y;
  localparam int unsigned PROD400_W   = COUNT_W + Q400_W;
  localparam int unsigned RECIP4_SH   = R100_W;
  localparam int unsigned RECIP4      = (1 << RECIP4_SH) / DAYS_4Y;
  localparam int unsigned PROD4_W     = R100_W + Q4_W + 1;

  localparam int unsigned LAST_QUAD = 24;
  localparam int unsigned MONTH_MAR = 3;
  localparam int unsigned MONTH_DEC = 12;
  localparam int unsigned DAY_LAST  = 31;

  localparam logic [YEAR_W-1:0]   RST_TARGET_YEAR  = YEAR_W'(2021);
  localparam logic [MONTH_W-1:0]  RST_TARGET_MONTH = MONTH_W'(12);
  localparam logic [DAY_W-1:0]    RST_TARGET_DAY   = DAY_W'(25);
  localparam logic [OFFSET_W-1:0] RST_OFFSET_DAYS  = OFFSET_W'(100);

  typedef enum logic [CIDX_W-1:0] {
    REG_TARGET_YEAR  = 2'd0,
    REG_TARGET_MONTH = 2'd1,
    REG_TARGET_DAY   = 2'd2,
    REG_OFFSET_DAYS  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
  } cdn_dc_ctl_t;

  // Days in a common year before the first of the given month.
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] res;
    case (m) inside
      4'd0, 4'd1: res = 9'd0;
      4'd2:       res = 9'd31;
      4'd3:       res = 9'd59;
      4'd4:       res = 9'd90;
      4'd5:       res = 9'd120;
      4'd6:       res = 9'd151;
      4'd7:       res = 9'd181;
      4'd8:       res = 9'd212;
      4'd9:       res = 9'd243;
      4'd10:      res = 9'd273;
      4'd11:      res = 9'd304;
      4'd12:      res = 9'd334;
      default:    res = 9'd365;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/cdn_day_count.sv =====
`timescale 1ns / 1ps

module cdn_day_count import cdn_pkg::*; (
  input  logic                clk,
  input  cdn_dc_ctl_t         ctl,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  output logic [COUNT_W-1:0]  count
);

  logic [YEAR_W-1:0]    yr_m1;
  logic [PROD100_W-1:0] n_prod;
  logic [PROD100_W-1:0] y_prod;

  logic [COUNT_W-1:0]   a_n365;
  logic [YEAR_W-3:0]    a_n4;
  logic [Q100_W-1:0]    a_q100n;
  logic [Q100_W-1:0]    a_qy100;
  logic [YEAR_W-1:0]    a_year;
  logic                 a_zero;
  logic [DOY_W-1:0]     a_small;
  logic                 a_late;

  logic [YEAR_W-1:0]    y_hund;
  logic                 leap;

  logic [COUNT_W-1:0]   b_base;
  logic [DOY_W-1:0]     b_small;

  assign yr_m1  = year - YEAR_W'(1);
  assign n_prod = PROD100_W'(yr_m1) * PROD100_W'(RECIP100);
  assign y_prod = PROD100_W'(year) * PROD100_W'(RECIP100);

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      a_n365  <= COUNT_W'(yr_m1) * COUNT_W'(DAYS_1Y);
      a_n4    <= yr_m1[YEAR_W-1:2];
      a_q100n <= n_prod[RECIP100_SH +: Q100_W];
      a_qy100 <= y_prod[RECIP100_SH +: Q100_W];
      a_year  <= year;
      a_zero  <= (year == '0);
      a_small <= days_before_month(month) + DOY_W'(day);
      a_late  <= (month >= MONTH_W'(MONTH_MAR));
    end
  end

  assign y_hund = YEAR_W'(a_qy100) * YEAR_W'(100);
  assign leap   = (a_year[1:0] == 2'b00) && ((y_hund != a_year) || (a_qy100[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      if (a_zero) begin
        b_base <= '0;
      end else begin
        b_base <= a_n365 + COUNT_W'(a_n4) - COUNT_W'(a_q100n)
                  + COUNT_W'(a_q100n[Q100_W-1:2]);
      end
      b_small <= a_small + DOY_W'(leap && a_late);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      count <= b_base + COUNT_W'(b_small);
    end
  end

endmodule

// ===== rtl/core/calendar_day_number_unit_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   in_year, in_month, in_day
// output    out_valid / out_stall day_number, weekday, days_to_target,
//                                 later_year, later_month, later_day, later_overflow
// config    cfg_we                cfg_index, cfg_data
//
// A date passes through a fourteen-stage pipeline, and one date is taken in every
// cycle unless the pipeline is stalled.
// The depth is set mostly by the constant divisions that turn the later day number
// back into a date; those by 400 and 4 years are split into multiply, product and correction stages.
// Reset clears the valid bits and loads the configuration defaults.
// A stall holds only the stages that are full; empty stages keep filling.

module calendar_day_number_unit_top import cdn_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [YEAR_W-1:0]          in_year,
  input  logic [MONTH_W-1:0]         in_month,
  input  logic [DAY_W-1:0]           in_day,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DN_W-1:0]            day_number,
  output logic [WD_W-1:0]            weekday,
  output logic signed [COUNT_W-1:0]  days_to_target,
  output logic [YEAR_W-1:0]          later_year,
  output logic [MONTH_W-1:0]         later_month,
  output logic [DAY_W-1:0]           later_day,
  output logic                       later_overflow,
  input  logic                       cfg_we,
  input  logic [CIDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int unsigned NST   = 14;
  localparam int unsigned CMP_W = 17;

  logic [YEAR_W-1:0]   tgt_year;
  logic [MONTH_W-1:0]  tgt_month;
  logic [DAY_W-1:0]    tgt_day;
  logic [OFFSET_W-1:0] off_days;

  logic [NST:1] vld;
  logic [NST:1] rdy;
  logic [NST:1] vfeed;

  cdn_dc_ctl_t         dc_ctl;
  logic [COUNT_W-1:0]  in_cnt;
  logic [COUNT_W-1:0]  tg_cnt;
  logic [OFFSET_W-1:0] a_off;
  logic [OFFSET_W-1:0] b_off;
  logic [OFFSET_W-1:0] c_off;

  logic [COUNT_W-1:0]  d_dn, d_dtt, d_n;
  logic                d_zero;

  logic [23:0]         wd_dig;
  logic [5:0]          wd_s1;
  logic [3:0]          wd_s2;
  logic [2:0]          wd_s3;
  logic [PROD400_W-1:0] q400_prod;

  logic [COUNT_W-1:0]  e_dn, e_dtt, e_n;
  logic                e_zero;
  logic [WD_W-1:0]     e_wd;
  logic [Q400_W-1:0]   e_q400e;

  logic [COUNT_W-1:0]  f_dn, f_dtt, f_n, f_p400;
  logic                f_zero;
  logic [WD_W-1:0]     f_wd;
  logic [Q400_W-1:0]   f_q400e;

  logic [COUNT_W-1:0]  g_t0;
  logic [R400_W:0]     g_t1;
  logic                g_ge;
  logic [COUNT_W-1:0]  g_dn, g_dtt;
  logic                g_zero;
  logic [WD_W-1:0]     g_wd;
  logic [Q400_W-1:0]   g_q400;
  logic [R400_W-1:0]   g_r;

  logic [1:0]          h_sel;
  logic [R400_W-1:0]   h_diff;
  logic [COUNT_W-1:0]  h_dn, h_dtt;
  logic                h_zero;
  logic [WD_W-1:0]     h_wd;
  logic [1:0]          h_q100;
  logic [R100_W-1:0]   h_r2;
  logic [LY_W-1:0]     h_ybase;

  logic [PROD4_W-1:0]  q4_prod;
  logic [COUNT_W-1:0]  i_dn, i_dtt;
  logic                i_zero;
  logic [WD_W-1:0]     i_wd;
  logic [1:0]          i_q100;
  logic [R100_W-1:0]   i_r2;
  logic [LY_W-1:0]     i_ybase;
  logic [Q4_W-1:0]     i_q4e;

  logic [COUNT_W-1:0]  j_dn, j_dtt;
  logic                j_zero;
  logic [WD_W-1:0]     j_wd;
  logic [1:0]          j_q100;
  logic [R100_W-1:0]   j_r2, j_p4;
  logic [LY_W-1:0]     j_ybase;
  logic [Q4_W-1:0]     j_q4e;

  logic [R100_W-1:0]   k_t0;
  logic [R4_W:0]       k_t1;
  logic                k_ge;
  logic [COUNT_W-1:0]  k_dn, k_dtt;
  logic                k_zero;
  logic [WD_W-1:0]     k_wd;
  logic [1:0]          k_q100;
  logic [LY_W-1:0]     k_ybase;
  logic [Q4_W-1:0]     k_q4;
  logic [R4_W-1:0]     k_r3;

  logic [1:0]          l_sel;
  logic [R4_W-1:0]     l_diff;
  logic [COUNT_W-1:0]  l_dn, l_dtt;
  logic                l_zero;
  logic [WD_W-1:0]     l_wd;
  logic [LY_W-1:0]     l_ly;
  logic                l_leap;
  logic [DOY_W-1:0]    l_r4;

  logic [12:2]         m_ge;
  logic [COUNT_W-1:0]  m_dn, m_dtt;
  logic                m_zero;
  logic [WD_W-1:0]     m_wd;
  logic [LY_W-1:0]     m_ly;
  logic                m_leap;
  logic [DOY_W-1:0]    m_r4;
  logic                m_ovf;
  logic [MONTH_W-1:0]  m_month;

  logic [DOY_W-1:0]    n_start;
  logic [DOY_W-1:0]    n_dom;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_year  <= RST_TARGET_YEAR;
      tgt_month <= RST_TARGET_MONTH;
      tgt_day   <= RST_TARGET_DAY;
      off_days  <= RST_OFFSET_DAYS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_YEAR:  tgt_year  <= cfg_data[YEAR_W-1:0];
        REG_TARGET_MONTH: tgt_month <= cfg_data[MONTH_W-1:0];
        REG_TARGET_DAY:   tgt_day   <= cfg_data[DAY_W-1:0];
        REG_OFFSET_DAYS:  off_days  <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its contents move on.
  assign vfeed   = {vld[NST-1:1], in_valid};
  assign rdy[NST] = !vld[NST] || !out_stall;
  for (genvar s = 1; s < NST; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 1; s <= NST; s++) begin
        if (rdy[s]) begin
          vld[s] <= vfeed[s];
        end
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[NST];

  // Stages 1 to 3: day numbers of the input date and of the target date.
  assign dc_ctl = '{en_a: rdy[1], en_b: rdy[2], en_c: rdy[3]};

  cdn_day_count u_cnt_in (
    .clk   (clk),
    .ctl   (dc_ctl),
    .year  (in_year),
    .month (in_month),
    .day   (in_day),
    .count (in_cnt)
  );

  cdn_day_count u_cnt_tgt (
    .clk   (clk),
    .ctl   (dc_ctl),
    .year  (tgt_year),
    .month (tgt_month),
    .day   (tgt_day),
    .count (tg_cnt)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) a_off <= off_days;
    if (rdy[2]) b_off <= a_off;
    if (rdy[3]) c_off <= b_off;
  end

  // Stage 4: difference to the target and the zero-based later day number.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      d_dn   <= in_cnt;
      d_dtt  <= tg_cnt - in_cnt;
      d_n    <= in_cnt + COUNT_W'(c_off) - COUNT_W'(1);
      d_zero <= (in_cnt == '0) && (c_off == '0);
    end
  end

  // Stage 5: weekday by folding octal digits (eight is one modulo seven),
  // and the estimated count of 400-year cycles.
  assign wd_dig = {1'b0, d_dn};
  assign wd_s1  = 6'(wd_dig[2:0]) + 6'(wd_dig[5:3]) + 6'(wd_dig[8:6])
                + 6'(wd_dig[11:9]) + 6'(wd_dig[14:12]) + 6'(wd_dig[17:15])
                + 6'(wd_dig[20:18]) + 6'(wd_dig[23:21]);
  assign wd_s2  = 4'(wd_s1[5:3]) + 4'(wd_s1[2:0]);
  assign wd_s3  = 3'(wd_s2[3]) + wd_s2[2:0];
  assign q400_prod = PROD400_W'(d_n) * PROD400_W'(RECIP400);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      e_dn    <= d_dn;
      e_dtt   <= d_dtt;
      e_n     <= d_n;
      e_zero  <= d_zero;
      e_wd    <= (wd_s3 == 3'd7) ? '0 : wd_s3;
      e_q400e <= q400_prod[RECIP400_SH +: Q400_W];
    end
  end

  // Stage 6: product of the estimate.
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      f_dn    <= e_dn;
      f_dtt   <= e_dtt;
      f_n     <= e_n;
      f_zero  <= e_zero;
      f_wd    <= e_wd;
      f_q400e <= e_q400e;
      f_p400  <= COUNT_W'(e_q400e) * COUNT_W'(DAYS_400Y);
    end
  end

  // Stage 7: correct the 400-year quotient and remainder.
  assign g_t0 = f_n - f_p400;
  assign g_t1 = g_t0[R400_W:0] - (R400_W+1)'(DAYS_400Y);
  assign g_ge = (g_t0 >= COUNT_W'(DAYS_400Y));

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      g_dn   <= f_dn;
      g_dtt  <= f_dtt;
      g_zero <= f_zero;
      g_wd   <= f_wd;
      g_q400 <= f_q400e + Q400_W'(g_ge);
      g_r    <= g_ge ? g_t1[R400_W-1:0] : g_t0[R400_W-1:0];
    end
  end

  // Stage 8: centuries, clamped to three.
  assign h_sel  = 2'(g_r >= R400_W'(DAYS_100Y)) + 2'(g_r >= R400_W'(2 * DAYS_100Y))
                + 2'(g_r >= R400_W'(3 * DAYS_100Y));
  assign h_diff = g_r - R400_W'(h_sel) * R400_W'(DAYS_100Y);

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      h_dn    <= g_dn;
      h_dtt   <= g_dtt;
      h_zero  <= g_zero;
      h_wd    <= g_wd;
      h_q100  <= h_sel;
      h_r2    <= h_diff[R100_W-1:0];
      h_ybase <= LY_W'(g_q400) * LY_W'(400) + LY_W'(h_sel) * LY_W'(100);
    end
  end

  // Stage 9: estimated count of 4-year blocks.
  assign q4_prod = PROD4_W'(h_r2) * PROD4_W'(RECIP4);

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      i_dn    <= h_dn;
      i_dtt   <= h_dtt;
      i_zero  <= h_zero;
      i_wd    <= h_wd;
      i_q100  <= h_q100;
      i_r2    <= h_r2;
      i_ybase <= h_ybase;
      i_q4e   <= q4_prod[RECIP4_SH +: Q4_W];
    end
  end

  // Stage 10: product of the estimate.
  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      j_dn    <= i_dn;
      j_dtt   <= i_dtt;
      j_zero  <= i_zero;
      j_wd    <= i_wd;
      j_q100  <= i_q100;
      j_r2    <= i_r2;
      j_ybase <= i_ybase;
      j_q4e   <= i_q4e;
      j_p4    <= R100_W'(i_q4e) * R100_W'(DAYS_4Y);
    end
  end

  // Stage 11: correct the 4-year quotient and remainder.
  assign k_t0 = j_r2 - j_p4;
  assign k_t1 = k_t0[R4_W:0] - (R4_W+1)'(DAYS_4Y);
  assign k_ge = (k_t0 >= R100_W'(DAYS_4Y));

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      k_dn    <= j_dn;
      k_dtt   <= j_dtt;
      k_zero  <= j_zero;
      k_wd    <= j_wd;
      k_q100  <= j_q100;
      k_ybase <= j_ybase;
      k_q4    <= j_q4e + Q4_W'(k_ge);
      k_r3    <= k_ge ? k_t1[R4_W-1:0] : k_t0[R4_W-1:0];
    end
  end

  // Stage 12: single years, clamped to three, the year itself and its leap flag.
  assign l_sel  = 2'(k_r3 >= R4_W'(DAYS_1Y)) + 2'(k_r3 >= R4_W'(2 * DAYS_1Y))
                + 2'(k_r3 >= R4_W'(3 * DAYS_1Y));
  assign l_diff = k_r3 - R4_W'(l_sel) * R4_W'(DAYS_1Y);

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      l_dn   <= k_dn;
      l_dtt  <= k_dtt;
      l_zero <= k_zero;
      l_wd   <= k_wd;
      l_ly   <= k_ybase + LY_W'(k_q4) * LY_W'(4) + LY_W'(l_sel) + LY_W'(1);
      l_leap <= (l_sel == 2'd3) && ((k_q4 != Q4_W'(LAST_QUAD)) || (k_q100 == 2'd3));
      l_r4   <= l_diff[DOY_W-1:0];
    end
  end

  // Stage 13: year range check and month search.
  always_comb begin
    for (int k = 2; k <= 12; k++) begin
      m_ge[k] = (l_r4 >= days_before_month(MONTH_W'(k))
                         + DOY_W'(l_leap && (k >= MONTH_MAR)));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      m_dn    <= l_dn;
      m_dtt   <= l_dtt;
      m_zero  <= l_zero;
      m_wd    <= l_wd;
      m_ly    <= l_ly;
      m_leap  <= l_leap;
      m_r4    <= l_r4;
      m_ovf   <= (CMP_W'(l_ly) > CMP_W'(MAX_YEAR));
      m_month <= MONTH_W'($countones(m_ge)) + MONTH_W'(1);
    end
  end

  // Stage 14: day of month and the output register.
  assign n_start = days_before_month(m_month)
                 + DOY_W'(m_leap && (m_month >= MONTH_W'(MONTH_MAR)));
  assign n_dom   = m_r4 - n_start + DOY_W'(1);

  always_ff @(posedge clk) begin
    if (rdy[14]) begin
      day_number     <= m_dn[DN_W-1:0];
      weekday        <= m_wd;
      days_to_target <= $signed(m_dtt);
      if (m_zero) begin
        later_year     <= YEAR_W'(1);
        later_month    <= MONTH_W'(1);
        later_day      <= DAY_W'(1);
        later_overflow <= 1'b0;
      end else if (m_ovf) begin
        later_year     <= YEAR_W'(MAX_YEAR);
        later_month    <= MONTH_W'(MONTH_DEC);
        later_day      <= DAY_W'(DAY_LAST);
        later_overflow <= 1'b1;
      end else begin
        later_year     <= m_ly[YEAR_W-1:0];
        later_month    <= m_month;
        later_day      <= n_dom[DAY_W-1:0];
        later_overflow <= 1'b0;
      end
    end
  end

endmodule
